@@ rtl/core/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared item types, the entry format and the operation and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  // Operation codes carried in the op field.
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // Status codes reported with every result.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Width of the capacity register and of the reported count.
  localparam int CAP_W = 5;

  // Input item.
  typedef struct packed {
    logic        op;
    logic [15:0] item_tag;
    logic        item_priority;
  } in_t;

  // Result item.
  typedef struct packed {
    logic [1:0]       status;
    logic [15:0]      served_tag;
    logic             served_priority;
    logic [CAP_W-1:0] entry_count;
  } out_t;

  // One stored entry.
  typedef struct packed {
    logic        prio;
    logic [15:0] tag;
  } entry_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/spq_cell.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the chain: holds an entry and shifts, inserts or holds it.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 5
) (
  input  wire logic                clk,
  input  wire spq_pkg::cell_ctrl_t ctrl,
  input  wire logic [CNT_W-1:0]    count,
  input  wire spq_pkg::entry_t     left_entry,
  input  wire logic                left_lower,
  input  wire spq_pkg::entry_t     right_entry,
  output spq_pkg::entry_t          entry,
  output logic                     lower
);

  spq_pkg::entry_t entry_r;
  spq_pkg::entry_t entry_nxt;
  logic            occupied;
  logic            at_tail;

  // The slot holds a live entry when its position lies below the count.
  assign occupied = CNT_W'(INDEX) < count;
  assign at_tail  = CNT_W'(INDEX) == count;

  // A live entry of lower priority than the new one must move back.
  assign lower = occupied && (entry_r.prio < ctrl.new_entry.prio);

  // Dequeue pulls from the right; enqueue takes the left neighbour when it
  // moves back, or the new entry at the insertion point.
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.deq) begin
      entry_nxt = right_entry;
    end else if (ctrl.enq) begin
      if (left_lower) begin
        entry_nxt = left_entry;
      end else if (lower || at_tail) begin
        entry_nxt = ctrl.new_entry;
      end
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

`default_nettype wire

@@ rtl/core/sorted_priority_queue_core.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue core
// Bounded queue of tagged entries kept in priority order by a cell chain.
// ----------------------------------------------------------------------------
// Each item (enqueue or dequeue) is accepted while start is high and its result
// appears on out_data with out_valid high in the following cycle, for that
// cycle only; the receiver cannot stall it. A new item may be accepted in
// every cycle, since the whole row of cells inserts or shifts at once. busy
// is high only while reset is asserted. Enqueues are rejected with a full
// status once the count reaches the capacity register or DEPTH.
`default_nettype none

module sorted_priority_queue_core #(
  parameter int DEPTH = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire spq_pkg::in_t              in_data,
  output logic                           out_valid,
  output spq_pkg::out_t                  out_data,
  input  wire logic                      cfg_we,
  input  wire logic [spq_pkg::CAP_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > spq_pkg::CAP_W) ? CNT_W : spq_pkg::CAP_W;

  logic [spq_pkg::CAP_W-1:0] capacity_r;
  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          count_nxt;
  logic                      out_valid_r;
  spq_pkg::out_t             out_r;
  spq_pkg::out_t             out_nxt;
  logic                      accept;
  logic                      full;
  logic                      empty;
  spq_pkg::cell_ctrl_t       ctrl;
  spq_pkg::entry_t           entry_w [DEPTH];
  logic                      lower_w [DEPTH];

  // Items are taken whenever start is high outside reset.
  assign busy   = !rst_n;
  assign accept = start && !busy;

  // Full when the count reaches the capacity or the physical depth.
  assign full  = (CMP_W'(count_r) >= CMP_W'(capacity_r)) ||
                 (CMP_W'(count_r) >= CMP_W'(DEPTH));
  assign empty = count_r == '0;

  // Control broadcast to the chain.
  always_comb begin
    ctrl.enq            = accept && (in_data.op == spq_pkg::OP_ENQ) && !full;
    ctrl.deq            = accept && (in_data.op == spq_pkg::OP_DEQ) && !empty;
    ctrl.new_entry.prio = in_data.item_priority;
    ctrl.new_entry.tag  = in_data.item_tag;
  end

  // Row of cells, each linked to both neighbours.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_pkg::entry_t left_e;
    spq_pkg::entry_t right_e;
    logic            left_l;

    if (i == 0) begin : g_first
      assign left_e = '0;
      assign left_l = 1'b0;
    end else begin : g_link_left
      assign left_e = entry_w[i-1];
      assign left_l = lower_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_link_right
      assign right_e = entry_w[i+1];
    end

    spq_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .count       (count_r),
      .left_entry  (left_e),
      .left_lower  (left_l),
      .right_entry (right_e),
      .entry       (entry_w[i]),
      .lower       (lower_w[i])
    );
  end

  // Count after the operation.
  always_comb begin
    count_nxt = count_r;
    if (ctrl.enq) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.deq) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // Result of the accepted item.
  always_comb begin
    out_nxt.status          = spq_pkg::ST_OK;
    out_nxt.served_tag      = '0;
    out_nxt.served_priority = 1'b0;
    out_nxt.entry_count     = spq_pkg::CAP_W'(count_nxt);
    if (in_data.op == spq_pkg::OP_ENQ) begin
      if (full) begin
        out_nxt.status = spq_pkg::ST_FULL;
      end
    end else if (empty) begin
      out_nxt.status = spq_pkg::ST_EMPTY;
    end else begin
      out_nxt.served_tag      = entry_w[0].tag;
      out_nxt.served_priority = entry_w[0].prio;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r  <= spq_pkg::CAP_W'(16);
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity_r <= cfg_wdata;
      end
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The count never exceeds the depth of the chain.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= CMP_W'(DEPTH))
    else $error("count exceeds depth");

  // A rejected enqueue leaves the count unchanged.
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.op == spq_pkg::OP_ENQ) && full) |=> $stable(count_r))
    else $error("count moved on rejected enqueue");

  // A successful enqueue grows the count by one.
  a_enq_inc: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.enq |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("count not incremented on enqueue");

  // A reported count matches the held count.
  a_out_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.entry_count == spq_pkg::CAP_W'(count_r)))
    else $error("reported count differs from held count");

  // Non-ok results and ok enqueue results carry zero served fields.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status != spq_pkg::ST_OK) || out_valid_r &&
     (out_r.status == spq_pkg::ST_OK) && !$past(ctrl.deq)) |->
    ((out_r.served_tag == '0) && !out_r.served_priority))
    else $error("served fields not zero");

endmodule

`default_nettype wire
